// ===== sv/fbc_pkg.sv =====
// Shared types and constants for the frustum box cull block.
// Used by fbc_mac and frustum_box_cull; depends on nothing else.
package fbc_pkg;

  // Edge length of one tile cube, in world units.
  localparam int TILE_SIZE = 64;

  // Matrix entries are signed Q16.16.
  localparam int MAT_W = 32;
  // A plane normal or offset is the exact sum or difference of two entries.
  localparam int N_W   = MAT_W + 1;
  // Tile grid coordinates are signed 13-bit integers.
  localparam int TILE_W = 13;
  // Vertex coordinates reach +/- 4096 * TILE_SIZE.
  localparam int P_W   = $clog2(4096 * TILE_SIZE + 1) + 1;
  // One term of the distance sum.
  localparam int PROD_W = N_W + P_W;
  // Three vertex terms and the offset, with headroom.
  localparam int ACC_W = PROD_W + 2;

  // Axis codes of the term being worked on.
  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] AXIS_OFS = 2'd3;

  // Input function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  // Last plane index (six planes, 0..5).
  localparam logic [2:0] LAST_PLANE = 3'd5;

  // Control that travels with one multiply-accumulate step.
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       sub;
    logic [1:0] k;
  } step_t;

endpackage

// ===== sv/fbc_mac.sv =====
// Shared arithmetic unit: forms one plane normal component, picks the
// matching cube vertex coordinate and registers their product.
// Depends on fbc_pkg.
module fbc_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  fbc_pkg::step_t                      step,
  input  logic signed [fbc_pkg::MAT_W-1:0]    a,
  input  logic signed [fbc_pkg::MAT_W-1:0]    b,
  input  logic signed [fbc_pkg::P_W-1:0]      base_x,
  input  logic signed [fbc_pkg::P_W-1:0]      base_y,
  output fbc_pkg::step_t                      step_q,
  output logic signed [fbc_pkg::PROD_W-1:0]   prod
);

  localparam logic signed [fbc_pkg::P_W-1:0] TILE_S = fbc_pkg::P_W'(fbc_pkg::TILE_SIZE);
  localparam logic signed [fbc_pkg::P_W-1:0] ONE    = fbc_pkg::P_W'(1);

  logic signed [fbc_pkg::N_W-1:0]    a_ext;
  logic signed [fbc_pkg::N_W-1:0]    b_ext;
  logic signed [fbc_pkg::N_W-1:0]    n;
  logic signed [fbc_pkg::P_W-1:0]    base;
  logic signed [fbc_pkg::P_W-1:0]    p;
  logic signed [fbc_pkg::PROD_W-1:0] n_wide;
  logic signed [fbc_pkg::PROD_W-1:0] p_wide;

  // Plane component: row 3 plus or minus the selected row.
  assign a_ext = {a[fbc_pkg::MAT_W-1], a};
  assign b_ext = {b[fbc_pkg::MAT_W-1], b};
  assign n     = step.sub ? (a_ext - b_ext) : (a_ext + b_ext);

  // Lower cube corner on this axis; z starts at zero.
  always_comb begin
    unique case (step.k)
      fbc_pkg::AXIS_X: base = base_x;
      fbc_pkg::AXIS_Y: base = base_y;
      default:         base = '0;
    endcase
  end

  // Positive vertex: upper corner where the normal is strictly positive.
  // The offset term is multiplied by one.
  always_comb begin
    if (step.k == fbc_pkg::AXIS_OFS) begin
      p = ONE;
    end else if (n > 0) begin
      p = base + TILE_S;
    end else begin
      p = base;
    end
  end

  assign n_wide = {{(fbc_pkg::PROD_W-fbc_pkg::N_W){n[fbc_pkg::N_W-1]}}, n};
  assign p_wide = {{(fbc_pkg::PROD_W-fbc_pkg::P_W){p[fbc_pkg::P_W-1]}}, p};

  // Product register and its control.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_q <= '0;
    end else begin
      step_q <= step;
    end
    prod <= n_wide * p_wide;
  end

endmodule

// ===== sv/frustum_box_cull.sv =====
// Frustum culling of tile cubes against a loaded 4x4 view-projection matrix.
// Top level; depends on fbc_pkg and fbc_mac.
//
// Usage: every input transaction on the s_ group carries a function code in
// s_tuser. A load (code 0) writes one Q16.16 matrix entry at (column, row)
// and is done in the cycle it is accepted; it produces no output. A test
// (code 1) checks the cube of one tile against the six frustum planes and
// produces one output transaction whose bit 0 is 1 when the tile is in view.
// A test runs 24 steps of the shared multiply unit (six planes, three axes
// plus offset each), then drains the product register in the drain state
// and posts the result in the finish state; the next item can be taken
// once the sequencer is back in idle. s_tready is low while a test is in
// progress. The result sits in an output register, so a new item can be
// accepted while it waits; a finished test holds until the previous result
// is taken when the receiver stalls. Reset clears the matrix to zero, drops
// m_tvalid and returns to idle.
module frustum_box_cull (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: mat_col[1:0], mat_row[3:2], mat_value[35:4], tile_x[48:36],
  //          tile_y[61:49], zero fill[63:62]
  input  logic [63:0] s_tdata,
  // s_tuser: func[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: in_view[0], zero fill[7:1]
  output logic [7:0]  m_tdata
);

  typedef enum logic [1:0] {IDLE, RUN, DRAIN, FINISH} state_t;

  localparam logic signed [fbc_pkg::P_W-1:0] TILE_S = fbc_pkg::P_W'(fbc_pkg::TILE_SIZE);

  state_t state;
  logic [2:0] plane;
  logic [1:0] k;
  logic outside;
  logic signed [fbc_pkg::ACC_W-1:0] acc;
  logic signed [fbc_pkg::P_W-1:0]   base_x;
  logic signed [fbc_pkg::P_W-1:0]   base_y;

  // Row 3 of every column, and rows 0..2 of every column.
  logic signed [fbc_pkg::MAT_W-1:0] row3 [4];
  logic signed [fbc_pkg::MAT_W-1:0] rlo  [4][3];

  // Unpacked input fields.
  logic        func;
  logic [1:0]  mat_col;
  logic [1:0]  mat_row;
  logic signed [fbc_pkg::MAT_W-1:0]  mat_value;
  logic signed [fbc_pkg::TILE_W-1:0] tile_x;
  logic signed [fbc_pkg::TILE_W-1:0] tile_y;
  logic signed [fbc_pkg::P_W-1:0]    tx_ext;
  logic signed [fbc_pkg::P_W-1:0]    ty_ext;

  logic accept;
  logic [1:0] axis_i;
  fbc_pkg::step_t step;
  fbc_pkg::step_t step_q;
  logic signed [fbc_pkg::MAT_W-1:0]  a;
  logic signed [fbc_pkg::MAT_W-1:0]  b;
  logic signed [fbc_pkg::PROD_W-1:0] prod;
  logic signed [fbc_pkg::ACC_W-1:0]  prod_ext;
  logic signed [fbc_pkg::ACC_W-1:0]  acc_next;

  assign func      = s_tuser[0];
  assign mat_col   = s_tdata[1:0];
  assign mat_row   = s_tdata[3:2];
  assign mat_value = s_tdata[35:4];
  assign tile_x    = s_tdata[48:36];
  assign tile_y    = s_tdata[61:49];
  assign tx_ext = {{(fbc_pkg::P_W-fbc_pkg::TILE_W){tile_x[fbc_pkg::TILE_W-1]}}, tile_x};
  assign ty_ext = {{(fbc_pkg::P_W-fbc_pkg::TILE_W){tile_y[fbc_pkg::TILE_W-1]}}, tile_y};

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  // Plane index: bits 2:1 pick the row, bit 0 picks the sign.
  assign axis_i = plane[2:1];

  // Step issued to the shared unit this cycle.
  always_comb begin
    step.valid = (state == RUN);
    step.first = (k == fbc_pkg::AXIS_X);
    step.last  = (k == fbc_pkg::AXIS_OFS);
    step.sub   = plane[0];
    step.k     = k;
  end

  assign a = row3[k];
  assign b = rlo[k][axis_i];

  fbc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .a      (a),
    .b      (b),
    .base_x (base_x),
    .base_y (base_y),
    .step_q (step_q),
    .prod   (prod)
  );

  // Accumulate the distance of the current plane.
  assign prod_ext = {{(fbc_pkg::ACC_W-fbc_pkg::PROD_W){prod[fbc_pkg::PROD_W-1]}}, prod};
  assign acc_next = (step_q.first ? '0 : acc) + prod_ext;

  // Matrix store.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 4; c++) begin
        row3[c] <= '0;
        for (int r = 0; r < 3; r++) begin
          rlo[c][r] <= '0;
        end
      end
    end else if (accept && func == fbc_pkg::FUNC_LOAD) begin
      if (mat_row == 2'd3) begin
        row3[mat_col] <= mat_value;
      end else begin
        rlo[mat_col][mat_row] <= mat_value;
      end
    end
  end

  // Sequencer, accumulator and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      plane    <= '0;
      k        <= '0;
      outside  <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      // The finish state posts the next result itself.
      if (m_tvalid && m_tready && state != FINISH) begin
        m_tvalid <= 1'b0;
      end

      if (step_q.valid) begin
        acc <= acc_next;
        if (step_q.last && acc_next < 0) begin
          outside <= 1'b1;
        end
      end

      unique case (state)
        IDLE: begin
          if (accept && func == fbc_pkg::FUNC_TEST) begin
            base_x  <= tx_ext * TILE_S;
            base_y  <= ty_ext * TILE_S;
            plane   <= '0;
            k       <= fbc_pkg::AXIS_X;
            outside <= 1'b0;
            state   <= RUN;
          end
        end
        RUN: begin
          k <= k + 2'd1;
          if (k == fbc_pkg::AXIS_OFS) begin
            if (plane == fbc_pkg::LAST_PLANE) begin
              state <= DRAIN;
            end else begin
              plane <= plane + 3'd1;
            end
          end
        end
        DRAIN: begin
          state <= FINISH;
        end
        FINISH: begin
          // Post the result once the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, ~outside};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
